// ===== rtl/cfp_pkg.sv =====
// shared constants, types and the level map for the candle flicker driver
`timescale 1ns / 1ps
package cfp_pkg;

    typedef logic [15:0] lcg_t;
    typedef logic [6:0]  duty_t;
    typedef logic [7:0]  burst_t;

    localparam int unsigned LCG_MUL      = 171;
    localparam int unsigned LCG_INC      = 11213;
    localparam int unsigned LCG_MOD      = 53125;
    localparam int unsigned LCG_SEED     = 7;
    // first value drawn after reset, one generator step past the seed
    localparam int unsigned LCG_FIRST    = (LCG_SEED * LCG_MUL + LCG_INC) % LCG_MOD;
    // floor(2^32 / modulus), quotient estimate is low by at most one
    localparam int unsigned RECIP_SHIFT  = 32;
    localparam longint unsigned LCG_RECIP = (64'd1 << RECIP_SHIFT) / 64'(LCG_MOD);

    localparam int unsigned PERIOD_UNITS = 100;
    localparam int unsigned BURST_RESET  = 7;
    localparam int unsigned LEVEL_COUNT  = 15;

    localparam logic [1:0] REG_BURST_PERIODS = 2'd0;

    localparam lcg_t CUT_TABLE [LEVEL_COUNT] = '{
        16'd40906, 16'd32406, 16'd27625, 16'd24969, 16'd22313, 16'd19656,
        16'd17000, 16'd14344, 16'd11688, 16'd9031, 16'd6375, 16'd3719,
        16'd1594, 16'd1063, 16'd531
    };

    localparam duty_t DUTY_TABLE [LEVEL_COUNT + 1] = '{
        7'd100, 7'd93, 7'd87, 7'd80, 7'd73, 7'd67, 7'd60, 7'd53,
        7'd47, 7'd40, 7'd33, 7'd27, 7'd20, 7'd13, 7'd7, 7'd1
    };

    // first threshold exceeded wins; walk from the last so the first overrides
    function automatic duty_t map_level(input lcg_t v);
        duty_t lvl;
        lvl = DUTY_TABLE[LEVEL_COUNT];
        for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
            if (v > CUT_TABLE[i])
            begin
                lvl = DUTY_TABLE[i];
            end
        end
        return lvl;
    endfunction

endpackage

// ===== rtl/cfp_apb.sv =====
// apb register file holding the burst length
`timescale 1ns / 1ps
module cfp_apb (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output cfp_pkg::burst_t     burst_periods
);
    import cfp_pkg::*;

    burst_t     burst_reg;
    logic [1:0] reg_index;

    assign reg_index = {1'b0, paddr[2]};
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_reg <= burst_t'(BURST_RESET);
        end
        else if (psel && penable && pwrite && reg_index == REG_BURST_PERIODS)
        begin
            burst_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_BURST_PERIODS: prdata = {24'd0, burst_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign burst_periods = burst_reg;

endmodule

// ===== rtl/cfp_lcg.sv =====
// generator unit: holds the next value and steps it in a short pipeline
`timescale 1ns / 1ps
module cfp_lcg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    output cfp_pkg::lcg_t value
);
    import cfp_pkg::*;

    lcg_t        value_reg;
    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [23:0] s1_x_reg, s2_x_reg;
    logic [7:0]  s2_q_reg;
    logic [16:0] s3_r_reg;

    logic [23:0] s1_x_next;
    logic [40:0] s2_prod;
    logic [23:0] s3_r_full;
    lcg_t        value_next;

    // x = 171 * v + 11213, stays below 2^24
    assign s1_x_next = 24'(value_reg) * 24'(LCG_MUL) + 24'(LCG_INC);
    assign s2_prod   = 41'(s1_x_reg) * 41'(LCG_RECIP);
    assign s3_r_full = s2_x_reg - 24'(s2_q_reg) * 24'(LCG_MOD);
    assign value_next = (s3_r_reg >= 17'(LCG_MOD)) ? 16'(s3_r_reg - 17'(LCG_MOD))
                                                  : s3_r_reg[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            value_reg    <= lcg_t'(LCG_FIRST);
        end
        else
        begin
            s1_valid_reg <= step;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (s3_valid_reg)
            begin
                value_reg <= value_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_x_reg <= s1_x_next;
        s2_x_reg <= s1_x_reg;
        s2_q_reg <= s2_prod[RECIP_SHIFT +: 8];
        s3_r_reg <= s3_r_full[16:0];
    end

    assign value = value_reg;

endmodule

// ===== rtl/candle_flicker_pwm_top.sv =====
// top level of the candle flicker pwm driver
`timescale 1ns / 1ps
// an accepted item's result is loaded straight into the output register
// throughput: one item per cycle, input is taken while a result waits if out_ready
// a draw steps the generator through its s1, s2 and s3 stages; draws are 100+ items apart
// reset: asynchronous, active low; seed 7, burst length 7, phase and period zero
// no clearing pass after reset, an item can be taken as soon as reset is released
module candle_flicker_pwm_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        advance,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        led_on,
    output logic [6:0]  level,
    output logic        new_level
);
    import cfp_pkg::*;

    burst_t     burst_periods;
    lcg_t       lcg_value;

    // pwm state
    duty_t      duty_reg, duty_next;
    logic [6:0] phase_reg, phase_next;
    burst_t     period_reg, period_next;

    // output register
    logic       out_valid_reg;
    logic       led_reg, led_next;
    duty_t      level_reg, level_next;
    logic       new_reg, new_next;

    logic       accept;
    logic       draw;
    burst_t     limit;
    logic       period_end;
    logic       burst_end;

    cfp_apb u_apb (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .burst_periods (burst_periods)
    );

    // generator holds the value for the next draw, restepped after each draw
    cfp_lcg u_lcg (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (draw),
        .value (lcg_value)
    );

    // skid-free output register: take an item whenever the slot frees this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // a new level is drawn at the first unit of every burst
    assign draw = accept && advance && phase_reg == 7'd0 && period_reg == 8'd0;

    // zero burst length acts as one
    assign limit      = (burst_periods == 8'd0) ? 8'd1 : burst_periods;
    assign period_end = phase_reg >= 7'(PERIOD_UNITS - 1);
    assign burst_end  = ({1'b0, period_reg} + 9'd1) >= {1'b0, limit};

    always_comb
    begin
        duty_next   = duty_reg;
        phase_next  = phase_reg;
        period_next = period_reg;
        if (draw)
        begin
            duty_next = map_level(lcg_value);
        end
        if (accept && advance)
        begin
            if (period_end)
            begin
                phase_next  = 7'd0;
                period_next = burst_end ? 8'd0 : period_reg + 8'd1;
            end
            else
            begin
                phase_next = phase_reg + 7'd1;
            end
        end
        // result uses the freshly drawn level when this unit draws
        level_next = duty_next;
        led_next   = phase_reg < duty_next;
        new_next   = draw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg      <= '0;
            phase_reg     <= '0;
            period_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            duty_reg   <= duty_next;
            phase_reg  <= phase_next;
            period_reg <= period_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            led_reg   <= led_next;
            level_reg <= level_next;
            new_reg   <= new_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign led_on    = led_reg;
    assign level     = level_reg;
    assign new_level = new_reg;

endmodule
